// ----- src/bounded_array_list_store_macros.svh -----
// assertion macros for the bounded list store checker
`ifndef BOUNDED_ARRAY_LIST_STORE_MACROS_SVH
`define BOUNDED_ARRAY_LIST_STORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define BALS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bounded list store check failed");

// next-cycle implication, quiet during reset
`define BALS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bounded list store check failed");

`endif

// ----- src/bals_pkg.sv -----
// shared types and constants of the bounded list store
package bals_pkg;

    localparam int CMD_W  = 4;
    localparam int POS_W  = 6;
    localparam int WORD_W = 32;
    localparam int TLEN_W = 7;
    localparam int STAT_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 4'd0,
        CMD_WRITE  = 4'd1,
        CMD_PUSH   = 4'd2,
        CMD_POP    = 4'd3,
        CMD_INSERT = 4'd4,
        CMD_ERASE  = 4'd5,
        CMD_CLEAR  = 4'd6,
        CMD_RESIZE = 4'd7,
        CMD_ASSIGN = 4'd8
    } bals_op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_RANGE  = 3'd1,
        ST_FULL   = 3'd2,
        ST_BADLEN = 3'd3,
        ST_EMPTY  = 3'd4
    } bals_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDWAIT,
        S_MOVE_RD,
        S_MOVE_WR,
        S_PUT,
        S_FILL,
        S_DONE
    } bals_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] word_value;
        logic [TLEN_W-1:0]        target_length;
    } bals_cmd_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_word;
        logic [TLEN_W-1:0]        length_now;
        bals_status_t             status;
        logic                     is_empty;
    } bals_result_t;

    typedef struct packed {
        logic idle;
        logic res_load;
    } bals_seq_stat_t;

endpackage

// ----- src/bals_if.sv -----
// command and result channel interfaces of the bounded list store
interface bals_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [bals_pkg::CMD_W-1:0]        command;
    logic [bals_pkg::POS_W-1:0]        position;
    logic signed [bals_pkg::WORD_W-1:0] word_value;
    logic [bals_pkg::TLEN_W-1:0]       target_length;

    modport source (output valid, command, position, word_value, target_length,
                    input ready);
    modport sink (input valid, command, position, word_value, target_length,
                  output ready);
endinterface

interface bals_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [bals_pkg::WORD_W-1:0] read_word;
    logic [bals_pkg::TLEN_W-1:0]       length_now;
    logic [bals_pkg::STAT_W-1:0]       status;
    logic                              is_empty;

    modport source (output valid, read_word, length_now, status, is_empty,
                    input ready);
    modport sink (input valid, read_word, length_now, status, is_empty,
                  output ready);
endinterface

// ----- src/bals_ram.sv -----
// generic single-write, single-read ram with registered read data
module bals_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/bals_seq.sv -----
// command sequencer with the shared index step and compare unit
module bals_seq #(
    parameter int MAX_ENTRIES = 64,
    parameter int WORD_BITS   = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  bals_pkg::bals_cmd_t            cmd_word,
    input  logic                           out_free,
    output bals_pkg::bals_seq_stat_t       stat,
    output bals_pkg::bals_result_t         result,
    output logic                           mem_we,
    output logic [$clog2(MAX_ENTRIES)-1:0] mem_waddr,
    output logic [WORD_BITS-1:0]           mem_wdata,
    output logic [$clog2(MAX_ENTRIES)-1:0] mem_raddr,
    input  logic [WORD_BITS-1:0]           mem_rdata
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int LW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (LW > bals_pkg::TLEN_W) ? LW : bals_pkg::TLEN_W;
    localparam int OW = bals_pkg::TLEN_W;
    localparam int DW = bals_pkg::WORD_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    bals_pkg::bals_state_t  state_reg, state_next;
    bals_pkg::bals_status_t status_reg, status_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        lim_reg, lim_next;
    logic [LW-1:0]        len_reg, len_next;
    logic [WORD_BITS-1:0] fill_reg, fill_next;
    logic [DW-1:0]        rd_reg, rd_next;
    logic                 down_reg, down_next;

    logic [CW-1:0]        pos_ext, len_ext, tlen_ext, nbr;
    logic                 last;
    logic                 bad_len;
    logic [WORD_BITS-1:0] val_conv;

    assign pos_ext  = CW'(cmd_word.position);
    assign len_ext  = CW'(len_reg);
    assign tlen_ext = CW'(cmd_word.target_length);
    assign bad_len  = (tlen_ext == '0) || (tlen_ext > MAX_C);
    assign val_conv = WORD_BITS'(cmd_word.word_value);

    // shared step and compare
    assign nbr  = down_reg ? (idx_reg - ONE_C) : (idx_reg + ONE_C);
    assign last = (nbr == lim_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bals_pkg::S_IDLE;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        idx_reg    <= idx_next;
        lim_reg    <= lim_next;
        fill_reg   <= fill_next;
        rd_reg     <= rd_next;
        down_reg   <= down_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        status_next   = status_reg;
        idx_next      = idx_reg;
        lim_next      = lim_reg;
        len_next      = len_reg;
        fill_next     = fill_reg;
        rd_next       = rd_reg;
        down_next     = down_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg[AW-1:0];
        mem_wdata     = fill_reg;
        mem_raddr     = nbr[AW-1:0];
        stat.idle     = 1'b0;
        stat.res_load = 1'b0;

        case (state_reg)
            bals_pkg::S_IDLE:
            begin
                stat.idle = 1'b1;
                mem_raddr = pos_ext[AW-1:0];
                if (start)
                begin
                    rd_next     = '0;
                    status_next = bals_pkg::ST_OK;
                    fill_next   = val_conv;
                    state_next  = bals_pkg::S_DONE;
                    case (bals_pkg::bals_op_t'(cmd_word.command))
                        bals_pkg::CMD_READ:
                        begin
                            if (pos_ext < len_ext)
                                state_next = bals_pkg::S_RDWAIT;
                            else
                                status_next = bals_pkg::ST_RANGE;
                        end
                        bals_pkg::CMD_WRITE:
                        begin
                            if (pos_ext < len_ext)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_ext[AW-1:0];
                                mem_wdata = val_conv;
                            end
                            else
                                status_next = bals_pkg::ST_RANGE;
                        end
                        bals_pkg::CMD_PUSH:
                        begin
                            if (len_ext >= MAX_C)
                                status_next = bals_pkg::ST_FULL;
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = len_ext[AW-1:0];
                                mem_wdata = val_conv;
                                len_next  = LW'(len_ext + ONE_C);
                            end
                        end
                        bals_pkg::CMD_POP:
                        begin
                            if (len_ext == '0)
                                status_next = bals_pkg::ST_EMPTY;
                            else
                                len_next = LW'(len_ext - ONE_C);
                        end
                        bals_pkg::CMD_INSERT:
                        begin
                            if (len_ext >= MAX_C)
                                status_next = bals_pkg::ST_FULL;
                            else if (pos_ext > len_ext)
                                status_next = bals_pkg::ST_RANGE;
                            else
                            begin
                                len_next = LW'(len_ext + ONE_C);
                                if (pos_ext == len_ext)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = pos_ext[AW-1:0];
                                    mem_wdata = val_conv;
                                end
                                else
                                begin
                                    // shift the tail up, top entry first
                                    idx_next   = len_ext;
                                    lim_next   = pos_ext;
                                    down_next  = 1'b1;
                                    state_next = bals_pkg::S_MOVE_RD;
                                end
                            end
                        end
                        bals_pkg::CMD_ERASE:
                        begin
                            if (pos_ext >= len_ext)
                                status_next = bals_pkg::ST_RANGE;
                            else
                            begin
                                len_next = LW'(len_ext - ONE_C);
                                if ((pos_ext + ONE_C) != len_ext)
                                begin
                                    // shift the tail down, lowest entry first
                                    idx_next   = pos_ext;
                                    lim_next   = len_ext - ONE_C;
                                    down_next  = 1'b0;
                                    state_next = bals_pkg::S_MOVE_RD;
                                end
                            end
                        end
                        bals_pkg::CMD_CLEAR:
                        begin
                            len_next = '0;
                        end
                        bals_pkg::CMD_RESIZE:
                        begin
                            if (bad_len)
                                status_next = bals_pkg::ST_BADLEN;
                            else
                            begin
                                len_next = LW'(tlen_ext);
                                if (tlen_ext > len_ext)
                                begin
                                    idx_next   = len_ext;
                                    lim_next   = tlen_ext;
                                    fill_next  = '0;
                                    down_next  = 1'b0;
                                    state_next = bals_pkg::S_FILL;
                                end
                            end
                        end
                        bals_pkg::CMD_ASSIGN:
                        begin
                            if (bad_len)
                                status_next = bals_pkg::ST_BADLEN;
                            else
                            begin
                                len_next   = LW'(tlen_ext);
                                idx_next   = '0;
                                lim_next   = tlen_ext;
                                down_next  = 1'b0;
                                state_next = bals_pkg::S_FILL;
                            end
                        end
                        default:
                        begin
                            status_next = bals_pkg::ST_OK;
                        end
                    endcase
                end
            end
            bals_pkg::S_RDWAIT:
            begin
                rd_next    = DW'(mem_rdata);
                state_next = bals_pkg::S_DONE;
            end
            bals_pkg::S_MOVE_RD:
            begin
                state_next = bals_pkg::S_MOVE_WR;
            end
            bals_pkg::S_MOVE_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                idx_next  = nbr;
                if (!last)
                    state_next = bals_pkg::S_MOVE_RD;
                else if (down_reg)
                    state_next = bals_pkg::S_PUT;
                else
                    state_next = bals_pkg::S_DONE;
            end
            bals_pkg::S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = lim_reg[AW-1:0];
                state_next = bals_pkg::S_DONE;
            end
            bals_pkg::S_FILL:
            begin
                mem_we   = 1'b1;
                idx_next = nbr;
                if (last)
                    state_next = bals_pkg::S_DONE;
            end
            bals_pkg::S_DONE:
            begin
                stat.res_load = out_free;
                if (out_free)
                    state_next = bals_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bals_pkg::S_IDLE;
            end
        endcase
    end

    assign result.read_word  = rd_reg;
    assign result.length_now = OW'(len_reg);
    assign result.status     = status_reg;
    assign result.is_empty   = (len_reg == '0);

endmodule

// ----- src/bounded_array_list_store.sv -----
// top level of the bounded list store: channels, result register, sequencer and ram
//
//  channel | dir | word contents                                   | handshake
//  cmd     | in  | command, position, word_value, target_length    | valid/ready
//  res     | out | read_word, length_now, status, is_empty          | valid/ready
//
// one command at a time; ready only while the sequencer is idle
// read waits on the registered ram data before its result; write/push/pop/clear
// and rejects go straight to done; insert and erase move any tail entries one at
// a time, a read then a write each, over the single ram write port and shared
// index step, and insert then puts the new word; a fill writes one entry per step
// reset clears only the length and control; list entries need no clearing pass
// a result waiting in the output register does not stop the next command
// from being taken; the sequencer holds its finish until the register frees
module bounded_array_list_store #(
    parameter int MAX_ENTRIES = 64,
    parameter int WORD_BITS   = 32
) (
    input logic        clk,
    input logic        rst_n,
    bals_cmd_if.sink   cmd,
    bals_res_if.source res
);

    localparam int AW = $clog2(MAX_ENTRIES);

    bals_pkg::bals_cmd_t      cmd_word;
    bals_pkg::bals_seq_stat_t stat;
    bals_pkg::bals_result_t   result;
    bals_pkg::bals_result_t   res_reg;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_free;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem_rdata;

    // incoming command word
    assign cmd_word.command       = cmd.command;
    assign cmd_word.position      = cmd.position;
    assign cmd_word.word_value    = cmd.word_value;
    assign cmd_word.target_length = cmd.target_length;

    assign cmd.ready = stat.idle;

    // output register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || res.ready;

    bals_seq #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .WORD_BITS   (WORD_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.valid && stat.idle),
        .cmd_word  (cmd_word),
        .out_free  (out_free),
        .stat      (stat),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // list entries, one word per entry
    bals_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // result register: load wins over drain
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (stat.res_load)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (stat.res_load)
            res_reg <= result;
    end

    assign res.valid      = out_valid_reg;
    assign res.read_word  = res_reg.read_word;
    assign res.length_now = res_reg.length_now;
    assign res.status     = res_reg.status;
    assign res.is_empty   = res_reg.is_empty;

endmodule

// ----- src/bals_chk.sv -----
// port-level checker for the bounded list store and its bind
`include "bounded_array_list_store_macros.svh"

module bals_chk #(
    parameter int MAX_ENTRIES = 64
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cmd_valid,
    input logic                              cmd_ready,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic signed [bals_pkg::WORD_W-1:0] read_word,
    input logic [bals_pkg::TLEN_W-1:0]       length_now,
    input logic [bals_pkg::STAT_W-1:0]       status,
    input logic                              is_empty
);

    localparam int OW = bals_pkg::TLEN_W;
    localparam logic [OW-1:0] FULL_LEN = OW'(MAX_ENTRIES);

    // a taken command leaves the block busy in the next cycle
    `BALS_ASSERT_NXT(busy_after_accept, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)

    // a stalled result stays offered
    `BALS_ASSERT_NXT(res_held, clk, rst_n, res_valid && !res_ready, res_valid)

    // full status only at capacity
    `BALS_ASSERT_IMP(full_at_cap, clk, rst_n,
        res_valid && (status == bals_pkg::ST_FULL), length_now == FULL_LEN)

    // failed pop leaves an empty list and no data
    `BALS_ASSERT_IMP(empty_pop, clk, rst_n,
        res_valid && (status == bals_pkg::ST_EMPTY), is_empty && (read_word == '0))

endmodule

bind bounded_array_list_store bals_chk #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_bals_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .read_word  (res.read_word),
    .length_now (res.length_now),
    .status     (res.status),
    .is_empty   (res.is_empty)
);
